// ----- hw/rtl/oksc_pkg.sv -----
package oksc_pkg;

  // wheel moduli and key weights
  localparam int unsigned ModA = 28;
  localparam int unsigned ModB = 24;
  localparam int unsigned ModC = 13;
  localparam int unsigned ModD = 12;

  localparam int unsigned WheelAW = 5;
  localparam int unsigned WheelBW = 5;
  localparam int unsigned WheelCW = 4;
  localparam int unsigned WheelDW = 4;

  // largest key is 32*27 + 10*23 + 9*12 + 3*11 = 1235
  localparam int unsigned KeyW = 11;
  localparam logic [KeyW-1:0] WeightA = 11'd32;
  localparam logic [KeyW-1:0] WeightB = 11'd10;
  localparam logic [KeyW-1:0] WeightC = 11'd9;
  localparam logic [KeyW-1:0] WeightD = 11'd3;

  // reciprocal constants for key / 26 and key / 10, scaled by 2^16
  localparam logic [11:0] Recip26 = 12'd2521;
  localparam logic [12:0] Recip10 = 13'd6554;
  localparam int unsigned RecipShift = 16;
  localparam logic [KeyW-1:0] Span26 = 11'd26;
  localparam logic [KeyW-1:0] Span10 = 11'd10;

  // character ranges
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7a;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5a;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 5;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  localparam cfg_idx_t CfgStartA   = 3'd0;
  localparam cfg_idx_t CfgStartB   = 3'd1;
  localparam cfg_idx_t CfgStartC   = 3'd2;
  localparam cfg_idx_t CfgStartD   = 3'd3;
  localparam cfg_idx_t CfgDirection = 3'd4;

  typedef struct packed {
    logic [WheelAW-1:0] start_a;
    logic [WheelBW-1:0] start_b;
    logic [WheelCW-1:0] start_c;
    logic [WheelDW-1:0] start_d;
    logic               encrypt;
  } cfg_t;

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_LOWER,
    CLS_UPPER,
    CLS_DIGIT
  } cls_e;

  typedef struct packed {
    cls_e            cls;
    logic [7:0]      ch;
    logic [KeyW-1:0] key;
  } qent_t;

endpackage

// ----- hw/rtl/oksc_if.sv -----
interface oksc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_in;

  modport source (output valid, output func, output char_in, input ready);
  modport sink   (input valid, input func, input char_in, output ready);
endinterface

interface oksc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;

  modport source (output valid, output char_out, input ready);
  modport sink   (input valid, input char_out, output ready);
endinterface

// ----- hw/rtl/odometer_keyed_shift_cipher_core.sv -----
// channel  | dir | handshake    | payload
// in_i     | in  | valid/ready  | func (1), char_in (8)
// out_o    | out | valid/ready  | char_out (8)
// cfg      | in  | cfg_we_i     | cfg_idx_i (3), cfg_wdata_i (5)
//
// one word per cycle sustained while the output is ready; a taken word passes the
// queue entry, the quotient stage and the output register in turn
// the wheel step in the front sets the feedback loop between words
// reset clears the wheels, start registers, direction (to encrypt) and all valids
// a stalled output holds its word while the two-entry queue keeps taking input until full
module odometer_keyed_shift_cipher_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  oksc_pkg::cfg_idx_t  cfg_idx_i,
  input  oksc_pkg::cfg_data_t cfg_wdata_i,
  oksc_in_if.sink             in_i,
  oksc_out_if.source          out_o
);
  import oksc_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  q_push, q_full, q_valid, q_pop;
  qent_t q_push_ent, q_head;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStartA:    cfg_d.start_a = cfg_wdata_i[WheelAW-1:0];
        CfgStartB:    cfg_d.start_b = cfg_wdata_i[WheelBW-1:0];
        CfgStartC:    cfg_d.start_c = cfg_wdata_i[WheelCW-1:0];
        CfgStartD:    cfg_d.start_d = cfg_wdata_i[WheelDW-1:0];
        CfgDirection: cfg_d.encrypt = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{start_a: '0, start_b: '0, start_c: '0, start_d: '0, encrypt: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  oksc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_ent_o  (q_push_ent)
  );

  oksc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_ent_i (q_push_ent),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .head_o     (q_head)
  );

  oksc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .encrypt_i (cfg_q.encrypt),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

// ----- hw/rtl/oksc_front.sv -----
module oksc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  oksc_pkg::cfg_t     cfg_i,
  oksc_in_if.sink            in_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output oksc_pkg::qent_t    q_ent_o
);
  import oksc_pkg::*;

  logic [WheelAW-1:0] wheel_a_q, wheel_a_d, load_a;
  logic [WheelBW-1:0] wheel_b_q, wheel_b_d, load_b;
  logic [WheelCW-1:0] wheel_c_q, wheel_c_d, load_c;
  logic [WheelDW-1:0] wheel_d_q, wheel_d_d, load_d;
  logic               accept;
  cls_e               cls;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign q_push_o   = accept;

  // start values at or above the modulus wrap once
  assign load_a = (cfg_i.start_a >= WheelAW'(ModA)) ? cfg_i.start_a - WheelAW'(ModA)
                                                    : cfg_i.start_a;
  assign load_b = (cfg_i.start_b >= WheelBW'(ModB)) ? cfg_i.start_b - WheelBW'(ModB)
                                                    : cfg_i.start_b;
  assign load_c = (cfg_i.start_c >= WheelCW'(ModC)) ? cfg_i.start_c - WheelCW'(ModC)
                                                    : cfg_i.start_c;
  assign load_d = (cfg_i.start_d >= WheelDW'(ModD)) ? cfg_i.start_d - WheelDW'(ModD)
                                                    : cfg_i.start_d;

  always_comb begin
    if (in_i.func) begin
      cls = CLS_OTHER;
    end else if (in_i.char_in >= ChLowerA && in_i.char_in <= ChLowerZ) begin
      cls = CLS_LOWER;
    end else if (in_i.char_in >= ChUpperA && in_i.char_in <= ChUpperZ) begin
      cls = CLS_UPPER;
    end else if (in_i.char_in >= ChDigit0 && in_i.char_in <= ChDigit9) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_OTHER;
    end
  end

  // key from the wheel positions before they step
  always_comb begin
    q_ent_o.cls = cls;
    q_ent_o.ch  = in_i.char_in;
    q_ent_o.key = WeightA * KeyW'(wheel_a_q) + WeightB * KeyW'(wheel_b_q)
                + WeightC * KeyW'(wheel_c_q) + WeightD * KeyW'(wheel_d_q);
  end

  // odometer step with carries, or reload of the start values on a function word
  always_comb begin
    wheel_a_d = wheel_a_q;
    wheel_b_d = wheel_b_q;
    wheel_c_d = wheel_c_q;
    wheel_d_d = wheel_d_q;
    if (accept && in_i.func) begin
      wheel_a_d = load_a;
      wheel_b_d = load_b;
      wheel_c_d = load_c;
      wheel_d_d = load_d;
    end else if (accept) begin
      if (wheel_a_q == WheelAW'(ModA - 1)) begin
        wheel_a_d = '0;
        if (wheel_b_q == WheelBW'(ModB - 1)) begin
          wheel_b_d = '0;
          if (wheel_c_q == WheelCW'(ModC - 1)) begin
            wheel_c_d = '0;
            wheel_d_d = (wheel_d_q == WheelDW'(ModD - 1)) ? '0 : wheel_d_q + 1'b1;
          end else begin
            wheel_c_d = wheel_c_q + 1'b1;
          end
        end else begin
          wheel_b_d = wheel_b_q + 1'b1;
        end
      end else begin
        wheel_a_d = wheel_a_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_a_q <= '0;
      wheel_b_q <= '0;
      wheel_c_q <= '0;
      wheel_d_q <= '0;
    end else begin
      wheel_a_q <= wheel_a_d;
      wheel_b_q <= wheel_b_d;
      wheel_c_q <= wheel_c_d;
      wheel_d_q <= wheel_d_d;
    end
  end

`ifndef SYNTHESIS
  a_wheels_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wheel_a_q < WheelAW'(ModA) && wheel_b_q < WheelBW'(ModB) &&
    wheel_c_q < WheelCW'(ModC) && wheel_d_q < WheelDW'(ModD))
    else $error("wheel position out of range");

  a_reload_loads_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.func |=> wheel_a_q == $past(load_a) && wheel_d_q == $past(load_d))
    else $error("reload did not load wheels");
`endif

endmodule

// ----- hw/rtl/oksc_queue.sv -----
module oksc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  oksc_pkg::qent_t    push_ent_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output oksc_pkg::qent_t    head_o
);
  import oksc_pkg::*;

  qent_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, wptr_d;
  logic [QPtrW-1:0]  rptr_q, rptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_ent_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

// ----- hw/rtl/oksc_back.sv -----
module oksc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               encrypt_i,
  input  logic               q_valid_i,
  input  oksc_pkg::qent_t    q_head_i,
  output logic               q_pop_o,
  oksc_out_if.source         out_o
);
  import oksc_pkg::*;

  logic [22:0] prod26;
  logic [23:0] prod10;

  // stage 1: quotients of key by 26 and by 10
  logic        s1_valid_q, s1_valid_d;
  qent_t       s1_ent_q;
  logic [5:0]  s1_q26_q;
  logic [6:0]  s1_q10_q;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_char_q, out_char_d;

  logic        out_adv, s1_adv;

  logic [KeyW-1:0] rem26_full, rem10_full;
  logic [4:0]      rem26;
  logic [3:0]      rem10;
  logic [7:0]      base;
  logic [5:0]      span, shift, offs, sum;

  assign out_adv = !out_valid_q || out_o.ready;
  assign s1_adv  = !s1_valid_q || out_adv;
  assign q_pop_o = q_valid_i && s1_adv;

  assign prod26 = 23'(q_head_i.key) * 23'(Recip26);
  assign prod10 = 24'(q_head_i.key) * 24'(Recip10);

  assign s1_valid_d = s1_adv ? q_valid_i : s1_valid_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_ent_q <= q_head_i;
      s1_q26_q <= prod26[RecipShift+5:RecipShift];
      s1_q10_q <= prod10[RecipShift+6:RecipShift];
    end
  end

  // stage 2: remainders and rotation
  always_comb begin
    rem26_full = s1_ent_q.key - Span26 * KeyW'(s1_q26_q);
    rem10_full = s1_ent_q.key - Span10 * KeyW'(s1_q10_q);
    if (rem26_full >= Span26) begin
      rem26_full = rem26_full - Span26;
    end
    if (rem10_full >= Span10) begin
      rem10_full = rem10_full - Span10;
    end
    rem26 = rem26_full[4:0];
    rem10 = rem10_full[3:0];
  end

  always_comb begin
    case (s1_ent_q.cls)
      CLS_LOWER: base = ChLowerA;
      CLS_UPPER: base = ChUpperA;
      CLS_DIGIT: base = ChDigit0;
      default:   base = '0;
    endcase
    if (s1_ent_q.cls == CLS_DIGIT) begin
      span  = 6'(Span10);
      shift = 6'(rem10);
    end else begin
      span  = 6'(Span26);
      shift = 6'(rem26);
    end
    offs = 6'(s1_ent_q.ch - base);
    sum  = encrypt_i ? offs + shift : offs + span - shift;
    if (sum >= span) begin
      sum = sum - span;
    end
    if (s1_ent_q.cls == CLS_OTHER) begin
      out_char_d = s1_ent_q.ch;
    end else begin
      out_char_d = base + 8'(sum);
    end
  end

  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_adv) begin
      out_char_q <= out_char_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.char_out = out_char_q;

endmodule
